>>> rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
// Used by the interfaces, controller, datapath, top level and checker.
package pal_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;

  // fixed item field widths
  localparam int CMD_W = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int LEN_W = 7;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request item
    logic start;       // set up shift index
    logic step;        // one shift step: read one entry, queue its write
    logic issue_read;  // read the addressed entry
    logic finish;      // commit and load the response register
  } pal_cmd_t;

  // datapath -> controller
  typedef struct packed {
    status_t code;
    logic    is_ins;
    logic    is_del;
    logic    is_rd;
    logic    more;     // shift steps remain
  } pal_stat_t;

endpackage

>>> rtl/pal_ifs.sv
// Valid/ready channel interfaces for request and response items.
// Depends on pal_pkg for field widths.
interface pal_req_if;
  import pal_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface pal_rsp_if;
  import pal_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] read_value;
  logic [LEN_W-1:0] length;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, status, read_value, length, is_empty, is_full, input ready);
  modport sink   (input valid, status, read_value, length, is_empty, is_full, output ready);
endinterface

>>> rtl/positional_array_list.sv
// Positional array list: ordered word store with insert/delete/read by position.
// Each item is checked; an insert or delete then moves one entry per cycle through
// the single-write, single-read entry memory before the response register is loaded.
// The next item is taken once the controller is back in idle.
// Reset (rst, synchronous): list empty, controller idle, no response pending.
// Depends on pal_pkg, pal_ifs, pal_ctrl and pal_dpath.
module positional_array_list #(
  parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pal_pkg::WORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pal_req_if.sink    req,
  pal_rsp_if.source  rsp
);
  import pal_pkg::*;

  pal_cmd_t  cmd;
  pal_stat_t stat;

  // Controller: sequences accept -> check -> shift steps -> finish.
  // The response register is loaded in finish; a new item can be accepted
  // while the previous response still waits, finish holds until it drains.
  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: entry memory is shifted one entry per step, reading the next
  // source entry while writing the one read the step before.
  pal_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (req.command),
    .position   (req.position),
    .value      (req.value),
    .status     (rsp.status),
    .read_value (rsp.read_value),
    .length     (rsp.length),
    .is_empty   (rsp.is_empty),
    .is_full    (rsp.is_full)
  );

endmodule

>>> rtl/pal_ctrl.sv
// Controller state machine for the positional array list.
// Depends on pal_pkg; drives pal_dpath through pal_cmd_t.
module pal_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  pal_pkg::pal_stat_t  stat,
  output pal_pkg::pal_cmd_t   cmd
);
  import pal_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE,
    S_FIN
  } state_t;

  state_t state;
  logic   ok;

  assign ok        = (stat.code == ST_OK);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.load = req_valid;
      S_CHECK: begin
        cmd.start      = ok && (stat.is_ins || stat.is_del);
        cmd.issue_read = ok && stat.is_rd;
      end
      S_MOVE:  cmd.step = stat.more;
      S_FIN:   cmd.finish = !rsp_valid || rsp_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // a new response replaces one that drains at the same edge
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (ok && (stat.is_ins || stat.is_del)) state <= S_MOVE;
          else state <= S_FIN;
        end
        S_MOVE: begin
          if (!stat.more) state <= S_FIN;  // last queued write lands this cycle
        end
        S_FIN: begin
          if (cmd.finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pal_dpath.sv
// Datapath for the positional array list: entry memory, count, shift
// index, status decode and response register. Depends on pal_pkg.
module pal_dpath #(
  parameter int CAPACITY   = pal_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pal_pkg::WORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pal_pkg::pal_cmd_t          cmd,
  output pal_pkg::pal_stat_t         stat,
  input  logic [pal_pkg::CMD_W-1:0]  command,
  input  logic [pal_pkg::POS_W-1:0]  position,
  input  logic [pal_pkg::VAL_W-1:0]  value,
  output logic [pal_pkg::ST_W-1:0]   status,
  output logic [pal_pkg::VAL_W-1:0]  read_value,
  output logic [pal_pkg::LEN_W-1:0]  length,
  output logic                       is_empty,
  output logic                       is_full
);
  import pal_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CMD_W-1:0]      op;
  logic [POS_W-1:0]      pos;
  logic [VAL_W-1:0]      val;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      idx;
  logic                  wpend;
  logic [ADDR_W-1:0]     waddr;
  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rdata;

  logic [CMP_W-1:0]            pe, ce, ie, pos_m1;
  logic [CNT_W-1:0]            idx_m1, idx_p1;
  logic [ADDR_W-1:0]           raddr, wa;
  logic [WORD_WIDTH-1:0]       wd, wval;
  logic [WORD_WIDTH+VAL_W-1:0] val_ext, rd_ext;
  logic                        we, re, is_ins, is_del, is_rd, ok;
  status_t                     code;

  assign pe     = CMP_W'(pos);
  assign ce     = CMP_W'(cnt);
  assign ie     = CMP_W'(idx);
  assign pos_m1 = pe - CMP_W'(1);
  assign idx_m1 = idx - CNT_W'(1);
  assign idx_p1 = idx + CNT_W'(1);

  assign is_ins = (op == CMD_INSERT);
  assign is_del = (op == CMD_DELETE);
  assign is_rd  = (op == CMD_READ);

  always_comb begin
    case (op)
      CMD_INSERT: begin
        if (pe == '0 || pe > ce + CMP_W'(1)) code = ST_BAD_POS;
        else if (cnt == CNT_W'(CAPACITY))    code = ST_FULL;
        else                                 code = ST_OK;
      end
      CMD_DELETE: begin
        if (cnt == '0)                 code = ST_EMPTY;
        else if (pe == '0 || pe > ce)  code = ST_BAD_POS;
        else                           code = ST_OK;
      end
      CMD_READ: begin
        if (pe == '0 || pe > ce) code = ST_BAD_POS;
        else                     code = ST_OK;
      end
      default: code = ST_BAD_POS;
    endcase
  end

  assign ok = (code == ST_OK);

  // insert walks idx down from count to pos, delete walks it up to count
  assign stat.code   = code;
  assign stat.is_ins = is_ins;
  assign stat.is_del = is_del;
  assign stat.is_rd  = is_rd;
  assign stat.more   = is_ins ? (ie >= pe) : (ie < ce);

  assign val_ext = {{WORD_WIDTH{1'b0}}, val};
  assign wval    = val_ext[WORD_WIDTH-1:0];
  assign rd_ext  = {{VAL_W{1'b0}}, rdata};

  assign re    = cmd.step || cmd.issue_read;
  assign raddr = cmd.step ? (is_ins ? idx_m1[ADDR_W-1:0] : idx[ADDR_W-1:0])
                          : pos_m1[ADDR_W-1:0];
  assign we    = wpend || (cmd.finish && is_ins && ok);
  assign wa    = wpend ? waddr : pos_m1[ADDR_W-1:0];
  assign wd    = wpend ? rdata : wval;

  always_comb begin
    cnt_next = cnt;
    if (ok && is_ins)      cnt_next = cnt + CNT_W'(1);
    else if (ok && is_del) cnt_next = cnt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      wpend <= 1'b0;
    end else begin
      wpend <= cmd.step;
      if (cmd.finish) cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= command;
      pos <= position;
      val <= value;
    end
    if (cmd.start) idx <= is_ins ? cnt : pe[CNT_W-1:0];
    else if (cmd.step) idx <= is_ins ? idx_m1 : idx_p1;
    if (cmd.step) waddr <= is_ins ? idx[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
    if (cmd.finish) begin
      status     <= code;
      read_value <= (is_rd && ok) ? rd_ext[VAL_W-1:0] : '0;
      length     <= LEN_W'(cnt_next);
      is_empty   <= (cnt_next == '0);
      is_full    <= (cnt_next == CNT_W'(CAPACITY));
    end
  end

  // one write and one registered read per cycle; never the same address
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/pal_chk.sv
// Port-level checks for the positional array list, bound to the top level.
// Depends on pal_pkg for status codes.
module pal_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [pal_pkg::ST_W-1:0]  status,
  input logic [pal_pkg::VAL_W-1:0] read_value,
  input logic                      is_empty,
  input logic                      is_full
);
  import pal_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before taken");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> is_empty)
    else $error("empty status without empty flag");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> is_full && !is_empty)
    else $error("full status without full flag");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_value == '0)
    else $error("refused item returned nonzero data");

endmodule

bind positional_array_list pal_chk u_pal_chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .read_value (rsp.read_value),
  .is_empty   (rsp.is_empty),
  .is_full    (rsp.is_full)
);

>>> tb/testbench.sv
// Self-checking bench for positional_array_list: directed and random insert, delete and read
// items with random idling on both channels, checked against a shadow copy of the list.
// Depends on pal_pkg, pal_ifs (pal_req_if, pal_rsp_if) and the positional_array_list RTL.
module testbench;
  import pal_pkg::*;

  localparam int LIST_CAP       = CAPACITY_DEF;
  localparam int WORD_W         = WORD_WIDTH_DEF;
  localparam int ITEM_GOAL      = 1550;
  localparam int QUIET_TAIL     = 150;          // last items run with no idling at all
  localparam int SWEEP_BUDGET   = 900;          // fill/drain sweeps stop once past this
  localparam int MAX_LATENCY    = LIST_CAP + 8; // insert at pos 1 of a 63-entry list, plus margin
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int MAX_PRINTED    = 40;

  // no command of the block uses this code; it must come back as a bad position
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
    logic             is_empty;
    logic             is_full;
  } list_result_t;

  logic clk;
  logic rst;

  pal_req_if req();
  pal_rsp_if rsp();

  positional_array_list uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // shadow copy of the list; only positions 1..shadow_len are ever read
  logic [WORD_W-1:0] shadow_words [LIST_CAP];
  int                shadow_len;

  list_result_t want_q [$];   // results still owed by the block, oldest first

  bit          idle_on;            // cleared for the quiet tail of the run
  bit          send_gappy;         // sender idles in this stretch
  bit          recv_gappy = 1'b1;  // receiver stalls in this stretch
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned full_hits;
  int unsigned status_tally [4];
  int unsigned hold_cnt = 0;
  int unsigned calm_cnt = 0;

  // 4-unit clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(4 * TIMEOUT_CYCLES);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic log_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Shadow list update for one accepted item; returns the result it must produce.
  // Order of checks matters: insert tests the position before fullness, delete
  // tests emptiness before the position.
  task automatic apply_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val, output list_result_t res);
    int p;
    int i;
    p = pos;
    res.status     = ST_OK;
    res.read_value = '0;
    if (cmd == CMD_INSERT) begin
      if (p < 1 || p > shadow_len + 1) begin
        res.status = ST_BAD_POS;
      end else if (shadow_len >= LIST_CAP) begin
        res.status = ST_FULL;
      end else begin
        // open a hole at p by moving p..len up one place
        for (i = shadow_len; i >= p; i--) shadow_words[i] = shadow_words[i-1];
        shadow_words[p-1] = val[WORD_W-1:0];
        shadow_len++;
        if (shadow_len == LIST_CAP) full_hits++;
      end
    end else if (cmd == CMD_DELETE) begin
      if (shadow_len == 0) begin
        res.status = ST_EMPTY;
      end else if (p < 1 || p > shadow_len) begin
        res.status = ST_BAD_POS;
      end else begin
        for (i = p; i < shadow_len; i++) shadow_words[i-1] = shadow_words[i];
        shadow_len--;
      end
    end else if (cmd == CMD_READ) begin
      if (p < 1 || p > shadow_len) res.status = ST_BAD_POS;
      else res.read_value = shadow_words[p-1];
    end else begin
      res.status = ST_BAD_POS;
    end
    res.length   = shadow_len[LEN_W-1:0];
    res.is_empty = (shadow_len == 0);
    res.is_full  = (shadow_len == LIST_CAP);
    status_tally[res.status]++;
  endtask

  // Drive one item at the falling edge, maybe after an idle burst, and hold it
  // until the block takes it. The expected result is queued at acceptance.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    list_result_t res;
    @(negedge clk);
    if (items_sent % 40 == 0) send_gappy = ($urandom_range(0, 3) != 0);
    if (idle_on && send_gappy && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.position <= pos;
    req.value    <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    apply_op(cmd, pos, val, res);
    want_q.push_back(res);
    items_sent++;
  endtask

  // One item biased toward growth (grow_pct) or shrinkage; mostly well-formed
  // positions, with some fully random noise that also hits the unused command.
  task automatic random_op(input int grow_pct);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) val = $urandom_range(0, 1) ? {VAL_W{1'b1}} : {VAL_W{1'b0}};
    else val = $urandom;
    if (roll < 8) begin
      cmd = CMD_W'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 127));
    end else if (roll < 28) begin
      cmd = CMD_READ;
      pos = (shadow_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, shadow_len));
    end else if ($urandom_range(0, 99) < grow_pct) begin
      cmd = CMD_INSERT;
      pos = POS_W'($urandom_range(1, shadow_len + 1));   // at capacity: full refusals
    end else begin
      cmd = CMD_DELETE;
      pos = (shadow_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, shadow_len));
    end
    send_item(cmd, pos, val);
  endtask

  // Empty-list refusals, bad positions, the unused command, value extremes and
  // inserts at front, middle and end of a short list.
  task automatic test_small_list();
    send_item(CMD_DELETE, 7'd1,   32'h0);          // delete on empty
    send_item(CMD_DELETE, 7'd0,   32'h0);          // empty wins over bad position
    send_item(CMD_READ,   7'd0,   32'h0);
    send_item(CMD_READ,   7'd1,   32'h0);          // read on empty
    send_item(CMD_INSERT, 7'd0,   32'h1234_5678);  // position 0 is never valid
    send_item(CMD_INSERT, 7'd2,   32'h1234_5678);  // beyond length+1
    send_item(CMD_UNUSED, 7'd1,   32'hffff_ffff);
    send_item(CMD_INSERT, 7'd1,   32'h0000_0000);
    send_item(CMD_INSERT, 7'd2,   32'hffff_ffff);  // append
    send_item(CMD_INSERT, 7'd1,   32'h5555_5555);  // push to front
    send_item(CMD_INSERT, 7'd127, 32'haaaa_aaaa);
    send_item(CMD_INSERT, 7'd2,   32'ha5a5_a5a5);  // middle
    for (int p = 0; p <= 5; p++) send_item(CMD_READ, p[POS_W-1:0], 32'hdead_beef);
    send_item(CMD_READ,   7'd127, 32'h0);
    send_item(CMD_DELETE, 7'd0,   32'h0);
    send_item(CMD_DELETE, 7'd5,   32'h0);          // one past length
    send_item(CMD_DELETE, 7'd2,   32'h0);          // middle
    send_item(CMD_UNUSED, 7'd127, 32'hffff_ffff);
    send_item(CMD_DELETE, 7'd3,   32'h0);          // last entry
  endtask

  // Grow the list to capacity, poke it at capacity, then shrink it to empty.
  task automatic test_fill_and_drain();
    while (items_sent < SWEEP_BUDGET) begin
      while (shadow_len < LIST_CAP) random_op(85);
      send_item(CMD_INSERT, POS_W'(LIST_CAP + 1), $urandom);   // good position, list full
      send_item(CMD_INSERT, POS_W'(LIST_CAP + 2), $urandom);   // bad position beats full
      send_item(CMD_INSERT, 7'd1, $urandom);
      send_item(CMD_READ,   POS_W'(LIST_CAP), 32'h0);
      send_item(CMD_READ,   POS_W'(LIST_CAP + 1), 32'h0);
      repeat (12) random_op(50);
      while (shadow_len > 0) random_op(15);
    end
  endtask

  // Wandering occupancy, alternating bias every hundred items.
  task automatic test_random_walk();
    while (items_sent < ITEM_GOAL - QUIET_TAIL)
      random_op(((items_sent / 100) % 2 == 0) ? 65 : 35);
  endtask

  // Back-to-back items with the response side always ready.
  task automatic test_quiet_tail();
    idle_on = 1'b0;
    while (items_sent < ITEM_GOAL) random_op(50);
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // Response backpressure: random bursts of stalled cycles, with calm stretches.
  always @(negedge clk) begin
    calm_cnt <= calm_cnt + 1;
    if (calm_cnt % 128 == 0) recv_gappy <= ($urandom_range(0, 2) != 0);
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else if (idle_on && recv_gappy && $urandom_range(0, 5) == 0) begin
      hold_cnt  <= $urandom_range(0, 8);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Result checker: every accepted result against the oldest owed one.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (want_q.size() == 0) begin
        log_mismatch($sformatf("result with nothing owed (status %0d len %0d)",
                               rsp.status, rsp.length));
      end else begin
        want = want_q.pop_front();
        if (rsp.status !== want.status)
          log_mismatch($sformatf("result %0d status %0d, want %s",
                                 results_seen, rsp.status, want.status.name()));
        if (rsp.read_value !== want.read_value)
          log_mismatch($sformatf("result %0d read_value %h, want %h",
                                 results_seen, rsp.read_value, want.read_value));
        if (rsp.length !== want.length)
          log_mismatch($sformatf("result %0d length %0d, want %0d",
                                 results_seen, rsp.length, want.length));
        if (rsp.is_empty !== want.is_empty)
          log_mismatch($sformatf("result %0d is_empty %b, want %b",
                                 results_seen, rsp.is_empty, want.is_empty));
        if (rsp.is_full !== want.is_full)
          log_mismatch($sformatf("result %0d is_full %b, want %b",
                                 results_seen, rsp.is_full, want.is_full));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    idle_on      = 1'b1;
    send_gappy   = 1'b1;
    shadow_len   = 0;
    items_sent   = 0;
    results_seen = 0;
    err_cnt      = 0;
    full_hits    = 0;
    for (int s = 0; s < 4; s++) status_tally[s] = 0;
    req.valid    = 1'b0;
    req.command  = CMD_INSERT;
    req.position = '0;
    req.value    = '0;

    // reset held over several rising edges, released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_small_list();
    test_fill_and_drain();
    test_random_walk();
    test_quiet_tail();

    // let every owed result arrive, then watch for strays a while longer
    while (want_q.size() != 0) @(posedge clk);
    repeat (MAX_LATENCY) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, list reached capacity %0d times",
             items_sent, results_seen, full_hits);
    $display("summary: status ok %0d, bad position %0d, full %0d, empty %0d; %0d mismatches",
             status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_FULL],
             status_tally[ST_EMPTY], err_cnt);
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
